// ----- hdl/ftfd_pkg.sv -----
// ---------------------------------------------------------------------------
// ftfd_pkg
// Shared types, frame constants and the 12-bit code conversion of the
// force/torque frame decoder.
// ---------------------------------------------------------------------------
package ftfd_pkg;

    localparam int WinDepth = 28;
    localparam int ShortLen = 12;
    localparam int LongLen  = 28;
    localparam int NumChan  = 6;
    localparam int FillW    = 5;

    localparam logic [7:0] HdrLo  = 8'h48;
    localparam logic [7:0] HdrHi  = 8'h49;
    localparam logic [7:0] Marker = 8'haa;
    localparam logic [7:0] Cr     = 8'h0d;
    localparam logic [7:0] Lf     = 8'h0a;

    typedef logic [7:0]                  win_byte_t;
    typedef win_byte_t [WinDepth-1:0]    window_t;
    typedef logic [31:0]                 chan_word_t;
    typedef chan_word_t [NumChan-1:0]    chan_set_t;
    typedef logic [FillW-1:0]            fill_t;

    // decoder verdict on the window after the current beat
    typedef struct packed {
        logic      hit;
        chan_set_t chan;
    } frame_res_t;

    // 12-bit sensor code to signed count; code 0x800 maps to zero
    function automatic chan_word_t code_to_count(input logic [11:0] code);
        logic [10:0] mag;
        mag = ~(code[10:0] - 11'd1);
        if (!code[11])
            code_to_count = {21'd0, code[10:0]};
        else
            code_to_count = 32'd0 - {21'd0, mag};
    endfunction

endpackage

// ----- hdl/ftfd_byte_cell.sv -----
// ---------------------------------------------------------------------------
// ftfd_byte_cell
// One stage of the byte window: takes the byte on its d input on every shift.
// ---------------------------------------------------------------------------
module ftfd_byte_cell
    import ftfd_pkg::*;
(
    input  logic      clk,
    input  logic      shift,
    input  win_byte_t d,
    output win_byte_t q
);

    win_byte_t data_reg;
    win_byte_t data_next;

    always_comb
    begin
        data_next = shift ? d : data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// ----- hdl/ftfd_frame_match.sv -----
// ---------------------------------------------------------------------------
// ftfd_frame_match
// Checks the newest bytes of the window against the short or long frame
// layout and unpacks the six channels.
// ---------------------------------------------------------------------------
module ftfd_frame_match
    import ftfd_pkg::*;
(
    input  window_t    win,
    input  logic       long_mode,
    input  logic       enough,
    output frame_res_t res
);

    localparam int ShortBase = WinDepth - ShortLen;
    localparam int LongBase  = WinDepth - LongLen;

    logic      short_ok;
    logic      long_ok;
    chan_set_t short_chan;
    chan_set_t long_chan;

    always_comb
    begin
        short_ok = (win[ShortBase] == HdrLo || win[ShortBase] == HdrHi)
                   && win[ShortBase+10] == Cr && win[ShortBase+11] == Lf;
        long_ok  = (win[LongBase] == HdrLo || win[LongBase] == HdrHi)
                   && win[LongBase+1] == Marker
                   && win[LongBase+26] == Cr && win[LongBase+27] == Lf;

        // two 12-bit codes per three bytes
        for (int k = 0; k < NumChan / 2; k++)
        begin
            short_chan[2*k] = code_to_count({win[ShortBase+1+3*k],
                                             win[ShortBase+2+3*k][7:4]});
            short_chan[2*k+1] = code_to_count({win[ShortBase+2+3*k][3:0],
                                               win[ShortBase+3+3*k]});
        end

        // little-endian words after header and marker
        for (int k = 0; k < NumChan; k++)
        begin
            long_chan[k] = {win[LongBase+5+4*k], win[LongBase+4+4*k],
                            win[LongBase+3+4*k], win[LongBase+2+4*k]};
        end

        res.hit  = enough && (long_mode ? long_ok : short_ok);
        res.chan = long_mode ? long_chan : short_chan;
    end

endmodule

// ----- hdl/force_torque_frame_decoder_top.sv -----
// ---------------------------------------------------------------------------
// force_torque_frame_decoder_top
// Sliding-window frame decoder for a force/torque sensor byte stream.
// ---------------------------------------------------------------------------
// One byte is taken per clock cycle while no result beat is stalled. Each
// byte shifts a row of 28 byte cells; the newest 12 (short mode) or 28 (long
// mode) bytes including the incoming one are checked in the same cycle, and
// a match loads the single output register, so the six channels show in the
// cycle after the frame's last byte and the window starts empty again. That
// output register is the only thing that throttles input: rx bytes stall only
// while a result beat is held waiting for out_ready. long_format may be written
// while no frame result is pending; the window is kept across a mode change.
module force_torque_frame_decoder_top
    import ftfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        long_format,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] force_x,
    output logic [31:0] force_y,
    output logic [31:0] force_z,
    output logic [31:0] torque_x,
    output logic [31:0] torque_y,
    output logic [31:0] torque_z
);

    localparam fill_t FillMax  = FillW'(WinDepth);
    localparam fill_t NeedShrt = FillW'(ShortLen);
    localparam fill_t NeedLong = FillW'(LongLen);

    logic       long_mode_reg;
    logic       long_mode_next;
    fill_t      fill_reg;
    fill_t      fill_next;
    fill_t      fill_inc;
    logic       out_valid_reg;
    logic       out_valid_next;
    chan_set_t  chan_reg;
    chan_set_t  chan_next;

    logic       in_acc;
    window_t    win_q;
    window_t    win_d;
    frame_res_t res;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_acc    = in_valid && in_ready;

    // window after this beat: each cell takes its newer neighbor
    genvar i;
    generate
        for (i = 0; i < WinDepth; i++)
        begin : g_cell
            if (i == WinDepth - 1)
            begin : g_newest
                assign win_d[i] = rx_byte;
            end
            else
            begin : g_inner
                assign win_d[i] = win_q[i+1];
            end
            ftfd_byte_cell u_cell (
                .clk   (clk),
                .shift (in_acc),
                .d     (win_d[i]),
                .q     (win_q[i])
            );
        end
    endgenerate

    assign fill_inc = (fill_reg == FillMax) ? fill_reg : fill_reg + 1'b1;

    ftfd_frame_match u_match (
        .win       (win_d),
        .long_mode (long_mode_reg),
        .enough    (fill_inc >= (long_mode_reg ? NeedLong : NeedShrt)),
        .res       (res)
    );

    always_comb
    begin
        long_mode_next = (cfg_valid && cfg_ready) ? long_format : long_mode_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !out_ready;
        chan_next      = chan_reg;
        if (in_acc)
        begin
            fill_next = res.hit ? '0 : fill_inc;
            if (res.hit)
            begin
                out_valid_next = 1'b1;
                chan_next      = res.chan;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_mode_reg <= 1'b0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            long_mode_reg <= long_mode_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chan_reg <= chan_next;
    end

    assign out_valid = out_valid_reg;
    assign force_x   = chan_reg[0];
    assign force_y   = chan_reg[1];
    assign force_z   = chan_reg[2];
    assign torque_x  = chan_reg[3];
    assign torque_y  = chan_reg[4];
    assign torque_z  = chan_reg[5];

endmodule

// ----- hdl/ftfd_checker.sv -----
// ---------------------------------------------------------------------------
// ftfd_checker
// Port-level checks of the frame decoder, bound to the top level.
// ---------------------------------------------------------------------------
module ftfd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] force_x,
    input logic [31:0] torque_z
);

    // a held result beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(force_x) && $stable(torque_z))
        else $error("result beat changed while stalled");

    // no byte is taken while the result slot is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("byte taken while result stalled");

    // a new result beat always follows an accepted byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without a preceding byte");

    // a fresh result after a taken one also needs a byte beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready ##1 out_valid |-> $past(in_valid && in_ready))
        else $error("back-to-back result without a byte");

endmodule

bind force_torque_frame_decoder_top ftfd_checker u_ftfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .force_x   (force_x),
    .torque_z  (torque_z)
);

// ----- bench/ftfd_frame_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ftfd_frame_checker
// Watches the byte, result and format channels of the frame decoder, keeps
// its own copy of the byte window, predicts every decoded frame and compares
// each result beat with the oldest predicted frame.
// ---------------------------------------------------------------------------
module ftfd_frame_checker
    import ftfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        long_format,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] force_x,
    input  logic [31:0] force_y,
    input  logic [31:0] force_z,
    input  logic [31:0] torque_x,
    input  logic [31:0] torque_y,
    input  logic [31:0] torque_z,
    output int          mismatches,
    output int          frames_pending
);

    logic [7:0] recent [WinDepth];
    int         held;
    logic       long_mode;
    chan_set_t  expected_frames [$];

    string chan_name [NumChan] = '{"force_x", "force_y", "force_z",
                                   "torque_x", "torque_y", "torque_z"};

    // 12-bit code to count: plain sign extension, except the code for -2048
    function automatic chan_word_t sensor_count(input logic [11:0] code);
        if (code == 12'h800)
            return '0;
        return {{20{code[11]}}, code};
    endfunction

    // check the newest bytes of the window against the current frame format
    function automatic logic decode_window(output chan_set_t chans);
        logic [7:0] b [LongLen];
        chans = '0;
        if (!long_mode)
        begin
            for (int i = 0; i < ShortLen; i++)
                b[i] = recent[WinDepth-ShortLen+i];
            if ((b[0] != HdrLo && b[0] != HdrHi) || b[10] != Cr || b[11] != Lf)
                return 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                chans[2*k]   = sensor_count({b[1+3*k], b[2+3*k][7:4]});
                chans[2*k+1] = sensor_count({b[2+3*k][3:0], b[3+3*k]});
            end
            return 1'b1;
        end
        for (int i = 0; i < LongLen; i++)
            b[i] = recent[WinDepth-LongLen+i];
        if ((b[0] != HdrLo && b[0] != HdrHi) || b[1] != Marker ||
            b[26] != Cr || b[27] != Lf)
            return 1'b0;
        for (int k = 0; k < NumChan; k++)
            chans[k] = {b[5+4*k], b[4+4*k], b[3+4*k], b[2+4*k]};
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        chan_set_t chans;
        chan_set_t seen;
        chan_set_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < WinDepth; i++)
                recent[i] = '0;
            held = 0;
            long_mode = 1'b0;
            expected_frames.delete();
            mismatches = 0;
            frames_pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                long_mode = long_format;

            if (out_valid && out_ready)
            begin
                seen = {torque_z, torque_y, torque_x, force_z, force_y, force_x};
                if (expected_frames.size() == 0)
                begin
                    $display("%0t: result beat with no frame expected, expected none, got %h",
                             $time, seen);
                    mismatches++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    for (int k = 0; k < NumChan; k++)
                        if (seen[k] !== want[k])
                        begin
                            $display("%0t: %s expected %h got %h",
                                     $time, chan_name[k], want[k], seen[k]);
                            mismatches++;
                        end
                end
            end

            if (in_valid && in_ready)
            begin
                for (int i = 0; i < WinDepth - 1; i++)
                    recent[i] = recent[i+1];
                recent[WinDepth-1] = rx_byte;
                if (held < WinDepth)
                    held++;
                // a matching frame empties the window
                if (held >= (long_mode ? LongLen : ShortLen) && decode_window(chans))
                begin
                    expected_frames.insert(expected_frames.size(), chans);
                    held = 0;
                end
            end

            frames_pending <= expected_frames.size();
        end
    end

endmodule

// ----- bench/tb_force_torque_frame_decoder_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_force_torque_frame_decoder_top
// Drives byte streams of short and long sensor frames, broken frames and
// noise into the frame decoder under random flow control, switches the frame
// format between phases and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb_force_torque_frame_decoder_top;
    import ftfd_pkg::*;

    localparam int ItemTarget    = 1950;
    localparam int HoldoffCycles = 400;
    localparam int QuietLimit    = 2000;
    localparam int SettleCycles  = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        long_format = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] force_x, force_y, force_z;
    logic [31:0] torque_x, torque_y, torque_z;

    int   mismatches;
    int   frames_pending;
    int   bytes_sent = 0;
    int   holdoff_asked = 0;
    bit   steady = 1'b0;
    logic cur_long = 1'b0;

    logic [7:0] burst [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    force_torque_frame_decoder_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .long_format (long_format),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .force_x     (force_x),
        .force_y     (force_y),
        .force_z     (force_z),
        .torque_x    (torque_x),
        .torque_y    (torque_y),
        .torque_z    (torque_z)
    );

    ftfd_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .long_format    (long_format),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .force_x        (force_x),
        .force_y        (force_y),
        .force_z        (force_z),
        .torque_x       (torque_x),
        .torque_y       (torque_y),
        .torque_z       (torque_z),
        .mismatches     (mismatches),
        .frames_pending (frames_pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [11:0] pick_code();
        if ($urandom_range(0, 99) < 25)
            case ($urandom_range(0, 5))
                0: return 12'h000;
                1: return 12'h7ff;
                2: return 12'h800;
                3: return 12'h801;
                4: return 12'hfff;
                default: return 12'h001;
            endcase
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic logic [31:0] pick_word();
        if ($urandom_range(0, 99) < 20)
            case ($urandom_range(0, 3))
                0: return 32'h0000_0000;
                1: return 32'hffff_ffff;
                2: return 32'h7f80_0000;
                default: return 32'h8000_0000;
            endcase
        return $urandom;
    endfunction

    function automatic logic [7:0] pick_header();
        return $urandom_range(0, 1) ? HdrHi : HdrLo;
    endfunction

    // queue one byte at the tail of the burst
    function automatic void add_byte(input logic [7:0] value);
        burst.insert(burst.size(), value);
    endfunction

    function automatic void append_short(input logic [7:0] head,
                                         input logic [5:0][11:0] codes);
        add_byte(head);
        for (int k = 0; k < 3; k++)
        begin
            add_byte(codes[2*k][11:4]);
            add_byte({codes[2*k][3:0], codes[2*k+1][11:8]});
            add_byte(codes[2*k+1][7:0]);
        end
        add_byte(Cr);
        add_byte(Lf);
    endfunction

    function automatic void append_long(input logic [7:0] head,
                                        input logic [5:0][31:0] words);
        add_byte(head);
        add_byte(Marker);
        for (int k = 0; k < NumChan; k++)
            for (int j = 0; j < 4; j++)
                add_byte(words[k][8*j +: 8]);
        add_byte(Cr);
        add_byte(Lf);
    endfunction

    task automatic send_byte(input logic [7:0] value);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_burst();
        foreach (burst[i])
            send_byte(burst[i]);
        burst.delete();
    endtask

    // stop sending and wait until every predicted frame has come out
    task automatic drain();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (frames_pending != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic set_format(input logic mode);
        drain();
        cfg_valid <= 1'b1;
        long_format <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_long = mode;
    endtask

    // one well-formed, broken or cut-off frame, or a run of noise bytes
    task automatic send_sequence();
        logic [5:0][11:0] codes;
        logic [5:0][31:0] words;
        logic             as_long;
        int               r;
        int               p;
        int               idx;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            as_long = cur_long ^ ($urandom_range(0, 9) == 0);
            if (as_long)
            begin
                foreach (words[k])
                    words[k] = pick_word();
                append_long(pick_header(), words);
            end
            else
            begin
                foreach (codes[k])
                    codes[k] = pick_code();
                append_short(pick_header(), codes);
            end
            if (r >= 62 && r < 74)
            begin
                // spoil the header, marker or trailer
                p = $urandom_range(0, as_long ? 3 : 2);
                idx = (p == 0) ? 0 : (p == 1) ? burst.size() - 2 :
                      (p == 2) ? burst.size() - 1 : 1;
                burst[idx] = burst[idx] ^ 8'($urandom_range(1, 255));
            end
            else if (r >= 74)
            begin
                repeat ($urandom_range(1, burst.size() - 1))
                    void'(burst.pop_back());
            end
        end
        else
        begin
            repeat ($urandom_range(1, 10))
                if ($urandom_range(0, 9) < 3)
                    case ($urandom_range(0, 4))
                        0: add_byte(HdrLo);
                        1: add_byte(HdrHi);
                        2: add_byte(Marker);
                        3: add_byte(Cr);
                        default: add_byte(Lf);
                    endcase
                else
                    add_byte(8'($urandom_range(0, 255)));
        end
        send_burst();
    endtask

    // receiver: random stalls after each beat, one long hold-off on request
    initial
    begin : result_sink
        int stall;
        int holdoff_seen;
        stall = 0;
        holdoff_seen = 0;
        forever
        begin
            @(posedge clk);
            if (holdoff_asked != holdoff_seen)
            begin
                holdoff_seen = holdoff_asked;
                stall = HoldoffCycles;
            end
            else if (stall != 0)
                stall--;
            else if (out_valid && out_ready)
                stall = pick_gap();
            out_ready <= (stall == 0);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        logic [5:0][11:0] codes;
        int               phase;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_format(1'b0);

        // code extremes, including the one that folds to zero
        append_short(HdrHi, {12'h001, 12'hfff, 12'h801, 12'h800, 12'h7ff, 12'h000});
        // bad line feed: no frame
        foreach (codes[k])
            codes[k] = pick_code();
        append_short(HdrLo, codes);
        burst[burst.size()-1] = 8'h0b;
        send_burst();

        phase = 0;
        while (bytes_sent < ItemTarget)
        begin
            if (phase == 3)
            begin
                // hold results back while frames keep coming, so input stalls
                set_format(1'b0);
                steady = 1'b1;
                holdoff_asked <= holdoff_asked + 1;
                repeat (4)
                begin
                    foreach (codes[k])
                        codes[k] = pick_code();
                    append_short(pick_header(), codes);
                end
                send_burst();
                steady = 1'b0;
            end
            set_format(phase < 2 ? phase[0] : 1'($urandom_range(0, 1)));
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(6, 16))
                send_sequence();
            phase++;
        end
        steady = 1'b0;
        drain();

        if (mismatches == 0 && frames_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
